/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* hw/rtl/mts_pkg.sv */
package mts_pkg;

  localparam int DEPTH       = 256;
  localparam int DATA_WIDTH  = 32;
  localparam int IO_WIDTH    = 32;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int OCC_W       = $clog2(DEPTH + 1);
  // Queue depth must be a power of two so the pointers wrap on their own.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP_WAIT
  } state_t;

  typedef struct packed {
    logic  is_pop;
    word_t value;
  } op_t;

  typedef struct packed {
    word_t value;
    word_t max;
  } entry_t;

  // Keep the low DATA_WIDTH bits of a port word, sign-extended.
  function automatic word_t to_word(input logic [IO_WIDTH-1:0] x);
    logic signed [63:0] t;
    t = 64'($signed(x));
    return t[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [IO_WIDTH-1:0] to_io(input word_t w);
    logic signed [63:0] t;
    t = 64'(w);
    return t[IO_WIDTH-1:0];
  endfunction

endpackage

/* hw/rtl/max_tracking_stack.sv */
// Bounded LIFO stack of signed words that also reports the running maximum.
// Input channel (in_valid/in_ready): in_command selects push (0) or pop (1);
// in_value is the word to push and is ignored on a pop.
// Result channel (out_valid/out_ready): exactly one transaction per input
// transaction, in order: the popped word (zero unless a pop succeeded), the
// maximum after the operation (zero when empty), an empty flag and a status
// code (ok, underflow on a pop of an empty stack, overflow when a push finds
// the stack full and the word is dropped).
// A push, or a pop that leaves the stack empty, passes from the queue slot to
// the result register; a pop that leaves one or more also waits on the memory read.
// Throughput: one push per cycle while out_ready stays high; a pop onto a
// remaining entry holds the execute stage in ST_POP_WAIT, set by the registered
// read of the entry memory that refills the top-of-stack registers.
// A two-entry queue sits between the command decoder and the execute stage,
// so input acceptance continues while a result waits on out_ready.
// When out_ready is low the result register holds its transaction, the
// execute stage stops, and in_ready drops once the queue fills.
// Reset (rst_n low, synchronous) empties the stack and the queue and drops
// out_valid; memory contents are not cleared and need no clearing pass.
module max_tracking_stack (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic signed [mts_pkg::IO_WIDTH-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mts_pkg::IO_WIDTH-1:0] out_popped_value,
  output logic signed [mts_pkg::IO_WIDTH-1:0] out_current_max,
  output logic                                out_is_empty,
  output logic [1:0]                          out_status
);
  import mts_pkg::*;

  // Decoded command from the front end into the queue.
  logic    dec_valid, dec_ready;
  op_t     dec_op;
  // Queue head toward the execute stage.
  logic    exe_valid, exe_ready;
  op_t     exe_op;
  status_t status;
  logic [IO_WIDTH-1:0] popped_bits, max_bits;

  mts_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_value   (in_value),
    .op_valid   (dec_valid),
    .op         (dec_op),
    .op_ready   (dec_ready)
  );

  mts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (dec_valid),
    .wr_ready (dec_ready),
    .wr_op    (dec_op),
    .rd_valid (exe_valid),
    .rd_ready (exe_ready),
    .rd_op    (exe_op)
  );

  mts_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .op_valid         (exe_valid),
    .op_ready         (exe_ready),
    .op               (exe_op),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (popped_bits),
    .out_current_max  (max_bits),
    .out_is_empty     (out_is_empty),
    .out_status       (status)
  );

  // Drive the signed result ports from the execute stage's bit vectors.
  assign out_popped_value = $signed(popped_bits);
  assign out_current_max  = $signed(max_bits);
  assign out_status       = status;

endmodule

/* hw/rtl/mts_front.sv */
module mts_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [mts_pkg::IO_WIDTH-1:0] in_value,
  output logic                         op_valid,
  output mts_pkg::op_t                 op,
  input  logic                         op_ready
);
  import mts_pkg::*;

  // Classify the command and bring the word to the stack width.
  assign op.is_pop = (in_command == CMD_POP);
  assign op.value  = (in_command == CMD_PUSH) ? to_word(in_value) : '0;
  assign op_valid  = in_valid;
  assign in_ready  = op_ready;

endmodule

/* hw/rtl/mts_queue.sv */
module mts_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  mts_pkg::op_t wr_op,
  output logic         rd_valid,
  input  logic         rd_ready,
  output mts_pkg::op_t rd_op
);
  import mts_pkg::*;

  op_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;

  assign wr_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_op    = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_op;
    end
  end

endmodule

/* hw/rtl/mts_back.sv */
module mts_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         op_valid,
  output logic                         op_ready,
  input  mts_pkg::op_t                 op,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mts_pkg::IO_WIDTH-1:0] out_popped_value,
  output logic [mts_pkg::IO_WIDTH-1:0] out_current_max,
  output logic                         out_is_empty,
  output mts_pkg::status_t             out_status
);
  import mts_pkg::*;

  state_t           state_r, state_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  word_t            top_val_r, top_val_nxt;
  word_t            top_max_r, top_max_nxt;

  logic             out_valid_r, out_valid_nxt;
  word_t            out_popped_r, out_popped_nxt;
  word_t            out_max_r, out_max_nxt;
  logic             out_empty_r, out_empty_nxt;
  status_t          out_status_r, out_status_nxt;

  // Entries below the top; the top entry lives in top_val_r/top_max_r.
  entry_t           mem [DEPTH];
  entry_t           rd_data_r;
  logic             wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  entry_t           wr_data;

  logic             out_free, take;
  logic             occ_is_zero, occ_is_one, occ_full;
  logic [OCC_W-1:0] occ_m1, occ_m2;
  word_t            push_max;

  assign out_free    = !out_valid_r || out_ready;
  assign take        = (state_r == ST_IDLE) && op_valid && out_free;
  assign occ_is_zero = (occ_r == '0);
  assign occ_is_one  = (occ_r == OCC_W'(1));
  assign occ_full    = (occ_r == OCC_W'(DEPTH));
  assign occ_m1      = occ_r - OCC_W'(1);
  assign occ_m2      = occ_r - OCC_W'(2);
  assign push_max    = (occ_is_zero || ($signed(op.value) > $signed(top_max_r))) ?
                       op.value : top_max_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take && op.is_pop && !occ_is_zero && !occ_is_one) begin
          state_nxt = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op_ready       = 1'b0;
    occ_nxt        = occ_r;
    top_val_nxt    = top_val_r;
    top_max_nxt    = top_max_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_popped_nxt = out_popped_r;
    out_max_nxt    = out_max_r;
    out_empty_nxt  = out_empty_r;
    out_status_nxt = out_status_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    wr_addr        = occ_m1[ADDR_W-1:0];
    wr_data        = '{value: top_val_r, max: top_max_r};
    rd_addr        = occ_m2[ADDR_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        op_ready = out_free;
        if (take) begin
          out_valid_nxt  = 1'b1;
          out_popped_nxt = '0;
          out_status_nxt = STATUS_OK;
          if (!op.is_pop) begin
            if (occ_full) begin
              out_status_nxt = STATUS_OVERFLOW;
              out_max_nxt    = top_max_r;
              out_empty_nxt  = 1'b0;
            end else begin
              wr_en         = !occ_is_zero;
              top_val_nxt   = op.value;
              top_max_nxt   = push_max;
              occ_nxt       = occ_r + OCC_W'(1);
              out_max_nxt   = push_max;
              out_empty_nxt = 1'b0;
            end
          end else if (occ_is_zero) begin
            out_status_nxt = STATUS_UNDERFLOW;
            out_max_nxt    = '0;
            out_empty_nxt  = 1'b1;
          end else if (occ_is_one) begin
            out_popped_nxt = top_val_r;
            occ_nxt        = occ_m1;
            out_max_nxt    = '0;
            out_empty_nxt  = 1'b1;
          end else begin
            rd_en         = 1'b1;
            occ_nxt       = occ_m1;
            out_valid_nxt = 1'b0;
          end
        end
      end
      ST_POP_WAIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_popped_nxt = top_val_r;
          out_max_nxt    = rd_data_r.max;
          out_empty_nxt  = 1'b0;
          out_status_nxt = STATUS_OK;
          top_val_nxt    = rd_data_r.value;
          top_max_nxt    = rd_data_r.max;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_val_r    <= top_val_nxt;
    top_max_r    <= top_max_nxt;
    out_popped_r <= out_popped_nxt;
    out_max_r    <= out_max_nxt;
    out_empty_r  <= out_empty_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = to_io(out_popped_r);
  assign out_current_max  = to_io(out_max_r);
  assign out_is_empty     = out_empty_r;
  assign out_status       = out_status_r;

endmodule

/* hw/rtl/mts_checker.sv */
`include "assert_macros.svh"

module mts_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [mts_pkg::IO_WIDTH-1:0] out_popped_value,
  input logic signed [mts_pkg::IO_WIDTH-1:0] out_current_max,
  input logic                                out_is_empty,
  input logic [1:0]                          out_status
);
  import mts_pkg::*;

  // A stalled result holds.
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_popped_value) && $stable(out_current_max) && $stable(out_status), "result changed while stalled")

  // Reset drops any pending result.
  `ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "out_valid after reset")

  // Underflow leaves an empty stack and returns nothing.
  `ASSERT_CLK(a_underflow, out_valid && (out_status == STATUS_UNDERFLOW) |-> out_is_empty && (out_popped_value == '0) && (out_current_max == '0), "bad underflow result")

  // Overflow happens only on a full, hence non-empty, stack.
  `ASSERT_CLK(a_overflow, out_valid && (out_status == STATUS_OVERFLOW) |-> !out_is_empty && (out_popped_value == '0), "bad overflow result")

  // An empty stack reports a zero maximum.
  `ASSERT_CLK(a_empty_max, out_valid && out_is_empty |-> (out_current_max == '0), "nonzero max on empty stack")

endmodule

bind max_tracking_stack mts_checker u_mts_checker (.*);

/* sim/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mts_pkg::*;

  // Cycles to hold after the last result so a stray transaction still shows up.
  localparam int HOLD_CYCLES = 8;
  localparam logic signed [IO_WIDTH-1:0] WORD_MIN = {1'b1, {(IO_WIDTH-1){1'b0}}};
  localparam logic signed [IO_WIDTH-1:0] WORD_MAX = {1'b0, {(IO_WIDTH-1){1'b1}}};

  // One expected result transaction.
  typedef struct {
    logic signed [IO_WIDTH-1:0] popped;
    logic signed [IO_WIDTH-1:0] top_max;
    logic                       empty;
    status_t                    status;
  } stack_result_t;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_valid   = 1'b0;
  logic                       in_ready;
  logic                       in_command = CMD_PUSH;
  logic signed [IO_WIDTH-1:0] in_value   = '0;
  logic                       out_valid;
  logic                       out_ready  = 1'b0;
  logic signed [IO_WIDTH-1:0] out_popped_value;
  logic signed [IO_WIDTH-1:0] out_current_max;
  logic                       out_is_empty;
  logic [1:0]                 out_status;

  // While set, neither side idles: gives stretches of back-to-back traffic.
  bit calm = 1'b0;
  int errors = 0;

  // Shadow copy of the stack: each entry keeps its word and the running max.
  word_t held_value [DEPTH];
  word_t held_max   [DEPTH];
  int    held_count = 0;

  // Results still owed by the block, oldest first.
  stack_result_t pending_results [$];

  // Walking word for rising and falling runs, so the max moves often.
  logic signed [IO_WIDTH-1:0] ramp_word = '0;

  max_tracking_stack DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_current_max  (out_current_max),
    .out_is_empty     (out_is_empty),
    .out_status       (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the shadow stack and return the result it owes.
  function automatic stack_result_t apply_stack_op(input logic cmd,
                                                   input logic signed [IO_WIDTH-1:0] raw);
    stack_result_t r;
    word_t         w;
    word_t         m;
    r.popped = '0;
    r.status = STATUS_OK;
    if (cmd == CMD_PUSH) begin
      if (held_count >= DEPTH) begin
        // Full: drop the word, leave the stack alone.
        r.status = STATUS_OVERFLOW;
      end else begin
        // Only the low DATA_WIDTH bits of the port word count.
        w = word_t'(raw);
        m = w;
        if (held_count > 0 && held_max[held_count-1] > w) begin
          m = held_max[held_count-1];
        end
        held_value[held_count] = w;
        held_max[held_count]   = m;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = STATUS_UNDERFLOW;
      end else begin
        held_count--;
        r.popped = held_value[held_count];
      end
    end
    r.top_max = (held_count > 0) ? held_max[held_count-1] : '0;
    r.empty   = (held_count == 0);
    return r;
  endfunction

  // Mix of extremes, small words around zero, ramps and full random words.
  function automatic logic signed [IO_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2, 3: return IO_WIDTH'(int'($urandom_range(0, 16)) - 8);
      4: begin
        ramp_word = ramp_word + IO_WIDTH'($urandom_range(1, 1000));
        return ramp_word;
      end
      5: begin
        ramp_word = ramp_word - IO_WIDTH'($urandom_range(1, 1000));
        return ramp_word;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    if (errors < 40) begin
      $display("%0t ERROR %s", $time, what);
    end
    errors++;
  endtask

  // Send one operation: idle at random, raise valid, hold until accepted.
  // in_ready is sampled on the falling edge so the rising edge decides cleanly.
  task automatic send_op(input logic cmd, input logic signed [IO_WIDTH-1:0] val);
    logic rdy;
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid   <= 1'b0;
      in_command <= 1'($urandom);
      in_value   <= $urandom;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    pending_results.push_back(apply_stack_op(cmd, val));
  endtask

  // Stall the result side at random unless a calm stretch is running.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 21);
  end

  // Check each result transaction. Outputs and out_ready are stable between the
  // falling edge and the next rising edge, where the transaction is taken.
  always @(negedge clk) begin : result_check
    stack_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected: popped %0d max %0d",
                                out_popped_value, out_current_max));
      end else begin
        want = pending_results.pop_front();
        if (out_popped_value !== want.popped) begin
          flag_mismatch($sformatf("popped_value got %0d want %0d",
                                  out_popped_value, want.popped));
        end
        if (out_current_max !== want.top_max) begin
          flag_mismatch($sformatf("current_max got %0d want %0d",
                                  out_current_max, want.top_max));
        end
        if (out_is_empty !== want.empty) begin
          flag_mismatch($sformatf("is_empty got %b want %b", out_is_empty, want.empty));
        end
        if (out_status !== want.status) begin
          flag_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
        end
      end
    end
  end

  // Extremes, underflow on an empty stack, max tracking up and down, and
  // the pushed word being ignored on a pop.
  task automatic test_directed_cases();
    send_op(CMD_POP, '0);
    send_op(CMD_POP, 32'h1234_5678);
    send_op(CMD_PUSH, '0);
    send_op(CMD_PUSH, WORD_MIN);
    send_op(CMD_PUSH, WORD_MAX);
    send_op(CMD_PUSH, -32'sd1);
    send_op(CMD_POP, '0);
    send_op(CMD_POP, '0);
    send_op(CMD_POP, '0);
    send_op(CMD_POP, '0);
    send_op(CMD_POP, '0);
    send_op(CMD_PUSH, WORD_MIN);
    send_op(CMD_PUSH, 32'hAAAA_AAAA);
    send_op(CMD_PUSH, 32'h5555_5555);
    send_op(CMD_POP, 32'hFFFF_FFFF);
    send_op(CMD_POP, '0);
    send_op(CMD_POP, '0);
    send_op(CMD_PUSH, 32'sd1);
    send_op(CMD_PUSH, 32'sd1);
    send_op(CMD_POP, '0);
    send_op(CMD_POP, '0);
  endtask

  // Fill to the brim without idling, push into a full stack, then drain
  // past empty with idling on both sides.
  task automatic test_fill_and_drain();
    calm = 1'b1;
    repeat (DEPTH) send_op(CMD_PUSH, pick_word());
    repeat (3) send_op(CMD_PUSH, pick_word());
    calm = 1'b0;
    send_op(CMD_POP, $urandom);
    send_op(CMD_PUSH, WORD_MAX);
    send_op(CMD_PUSH, pick_word());
    repeat (DEPTH + 2) send_op(CMD_POP, $urandom);
  endtask

  // Random push/pop walk; the push share shifts every few dozen operations
  // so the stack climbs, hovers and drains. Open with a calm stretch.
  task automatic test_random_walk(input int count);
    int push_pct;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 15;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      calm = (i < 120);
      if ($urandom_range(0, 99) < push_pct) begin
        send_op(CMD_PUSH, pick_word());
      end else begin
        send_op(CMD_POP, $urandom);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    // Hold reset, then release it on a rising edge.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_fill_and_drain();
    test_random_walk(505);
    in_valid <= 1'b0;

    // Drain every owed result, then watch a little longer for extras.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("PASS max_tracking_stack");
    end else begin
      $display("FAIL max_tracking_stack");
    end
    $finish;
  end

  // Bail out if the run hangs.
  initial begin
    #2_000_000;
    $display("FAIL max_tracking_stack");
    $finish;
  end

endmodule
